/* hw/rtl/vm_move_push_pop_unit_top_macros.svh */
// assertion helpers for the move/push/pop unit
`ifndef VM_MOVE_PUSH_POP_UNIT_TOP_MACROS_SVH
`define VM_MOVE_PUSH_POP_UNIT_TOP_MACROS_SVH

// implication checked on every clock edge out of reset
`define VMPP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication with the consequent checked in the next cycle
`define VMPP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/vmpp_pkg.sv */
`default_nettype none
package vmpp_pkg;
	localparam int MemBytes = 8192;
	localparam int RegCount = 32;
	localparam int AddrW = $clog2(MemBytes);
	localparam int SpW = AddrW + 1;
	localparam int RegIdxW = $clog2(RegCount);

	localparam logic [2:0] CMD_HALT = 3'd0;
	localparam logic [2:0] CMD_NOP = 3'd1;
	localparam logic [2:0] CMD_MOVE = 3'd2;
	localparam logic [2:0] CMD_PUSH = 3'd3;
	localparam logic [2:0] CMD_POP = 3'd4;

	localparam logic [2:0] KIND_REG = 3'd0;
	localparam logic [2:0] KIND_IMM = 3'd1;
	localparam logic [2:0] KIND_PTR = 3'd2;
	localparam logic [2:0] KIND_IND = 3'd3;
	localparam logic [2:0] KIND_DISP = 3'd4;

	localparam logic [2:0] ST_DONE = 3'd0;
	localparam logic [2:0] ST_HALT = 3'd1;
	localparam logic [2:0] ST_INVALID = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_UNDERFLOW = 3'd4;
	localparam logic [2:0] ST_IGNORED = 3'd5;

	typedef struct packed {
		logic [2:0] cmd;
		logic [2:0] src_kind;
		logic [1:0] src_size_code;
		logic [4:0] src_reg;
		logic [63:0] src_value;
		logic [2:0] dst_kind;
		logic [1:0] dst_size_code;
		logic [4:0] dst_reg;
		logic [63:0] dst_value;
	} in_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [13:0] stack_pointer_now;
		logic [63:0] moved_value;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_RDREG, S_ADDR, S_CHECK, S_BYTE_RD, S_BYTE_WAIT, S_BYTE_WR,
		S_REG_WB, S_RESULT
	} state_t;

	// memory port request from the sequencer to the byte memory
	typedef struct packed {
		logic we;
		logic [AddrW-1:0] addr;
		logic [7:0] wdata;
	} mem_req_t;
endpackage
`default_nettype wire

/* hw/rtl/vmpp_byte_mem.sv */
`default_nettype none
module vmpp_byte_mem (
	input wire logic clk,
	input wire vmpp_pkg::mem_req_t req,
	output logic [7:0] rdata
);
	import vmpp_pkg::*;
	logic [7:0] mem [MemBytes];
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata <= mem[req.addr];
	end
endmodule
`default_nettype wire

/* hw/rtl/vmpp_regfile.sv */
`default_nettype none
module vmpp_regfile (
	input wire logic clk,
	input wire logic we,
	input wire logic [vmpp_pkg::RegIdxW-1:0] waddr,
	input wire logic [63:0] wdata,
	input wire logic [vmpp_pkg::RegIdxW-1:0] raddr,
	output logic [63:0] rdata
);
	import vmpp_pkg::*;
	logic [63:0] regs [RegCount];
	always_ff @(posedge clk) begin
		if (we) begin
			regs[waddr] <= wdata;
		end
		rdata <= regs[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/vm_move_push_pop_unit_top.sv */
`default_nettype none
// move/push/pop instruction unit
// in channel: in_valid/in_ready carry one instruction word (in_data)
// out channel: out_valid/out_ready carry one status word (out_data) per
// instruction, with the stack pointer afterward and the bytes moved
// each instruction runs through a small sequencer: register reads, address
// check, then one byte per step through the single byte-memory port
// (read, wait, write), with a register write-back step after the last byte
// when the destination is a register; halt and nop go from the check
// straight to the result and skip the byte steps
// one instruction at a time: in_ready is high only in the idle state
// after reset a clearing pass zeroes the byte memory and the register file,
// one entry per cycle over all MemBytes (8192) addresses, while in_ready stays low
// a halt or any error sets the stop flag; later words return status
// ignored until the next reset
// if the receiver stalls, the result holds in the output register and the
// next instruction waits
module vm_move_push_pop_unit_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire vmpp_pkg::in_word_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output vmpp_pkg::out_word_t out_data
);
	import vmpp_pkg::*;
`include "vm_move_push_pop_unit_top_macros.svh"

	state_t state_q, state_d;
	in_word_t ins_q;
	logic [SpW-1:0] sp_q, sp_d;
	logic stopped_q, stopped_d;
	logic [AddrW:0] clr_q, clr_d;
	logic [63:0] sreg_q, dreg_q, sreg_d, dreg_d;
	logic [63:0] saddr_q, daddr_q, saddr_d, daddr_d;
	logic [3:0] idx_q, idx_d;
	logic [63:0] moved_q, moved_d;
	logic [7:0] byte_q, byte_d;
	logic [2:0] status_q, status_d;
	logic out_valid_q, out_valid_d;
	logic [SpW-1:0] stk_q, stk_d;

	mem_req_t mreq;
	logic [7:0] mrdata;
	logic rf_we;
	logic [RegIdxW-1:0] rf_waddr, rf_raddr;
	logic [63:0] rf_wdata, rf_rdata;

	vmpp_byte_mem u_mem (.clk(clk), .req(mreq), .rdata(mrdata));
	vmpp_regfile u_rf (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rf_raddr), .rdata(rf_rdata)
	);

	// decoded operands
	logic [3:0] ssize, dsize, xsize;
	logic is_move, is_push, is_pop, use_src, use_dst;
	logic [2:0] cmd;
	always_comb begin
		cmd = ins_q.cmd;
		ssize = 4'd1 << ins_q.src_size_code;
		dsize = 4'd1 << ins_q.dst_size_code;
		is_move = (cmd == CMD_MOVE);
		is_push = (cmd == CMD_PUSH);
		is_pop = (cmd == CMD_POP);
		use_src = is_move || is_push;
		use_dst = is_move || is_pop;
		xsize = is_pop ? dsize : ssize;
	end

	function automatic logic kind_mem(input logic [2:0] k);
		return (k == KIND_PTR) || (k == KIND_IND) || (k == KIND_DISP);
	endfunction

	function automatic logic addr_ok(input logic [63:0] a, input logic [3:0] sz);
		return a <= (64'(MemBytes) - 64'(sz));
	endfunction

	logic src_ok, dst_ok;
	always_comb begin
		src_ok = (ins_q.src_kind == KIND_REG) || (ins_q.src_kind == KIND_IMM)
			|| (kind_mem(ins_q.src_kind) && addr_ok(saddr_q, xsize));
		dst_ok = (ins_q.dst_kind == KIND_REG)
			|| (kind_mem(ins_q.dst_kind) && addr_ok(daddr_q, xsize));
		if (32'(ins_q.src_reg) >= RegCount && ins_q.src_kind != KIND_IMM
			&& ins_q.src_kind != KIND_PTR) src_ok = 1'b0;
		if (32'(ins_q.dst_reg) >= RegCount && ins_q.dst_kind != KIND_IMM
			&& ins_q.dst_kind != KIND_PTR) dst_ok = 1'b0;
	end

	// source byte at current index
	logic [7:0] src_byte_now;
	logic [5:0] sh;
	always_comb begin
		sh = {idx_q[2:0], 3'b000};
		case (ins_q.src_kind)
			KIND_REG: src_byte_now = 8'(sreg_q >> sh);
			KIND_IMM: src_byte_now = 8'(ins_q.src_value >> sh);
			default: src_byte_now = 8'h00;
		endcase
	end

	logic src_from_mem, dst_to_mem;
	always_comb begin
		src_from_mem = is_pop || kind_mem(ins_q.src_kind);
		dst_to_mem = is_push || kind_mem(ins_q.dst_kind);
	end

	always_comb begin
		state_d = state_q;
		sp_d = sp_q;
		stopped_d = stopped_q;
		clr_d = clr_q;
		sreg_d = sreg_q;
		dreg_d = dreg_q;
		saddr_d = saddr_q;
		daddr_d = daddr_q;
		idx_d = idx_q;
		moved_d = moved_q;
		byte_d = byte_q;
		status_d = status_q;
		out_valid_d = out_valid_q;
		stk_d = stk_q;
		mreq = '0;
		rf_we = 1'b0;
		rf_waddr = ins_q.dst_reg[RegIdxW-1:0];
		rf_wdata = dreg_q;
		rf_raddr = ins_q.src_reg[RegIdxW-1:0];
		in_ready = 1'b0;
		if (out_valid_q && out_ready) out_valid_d = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mreq.we = 1'b1;
				mreq.addr = clr_q[AddrW-1:0];
				rf_we = (32'(clr_q) < RegCount);
				rf_waddr = clr_q[RegIdxW-1:0];
				rf_wdata = '0;
				clr_d = clr_q + 1'b1;
				if (32'(clr_q) == MemBytes - 1) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = !out_valid_q;
				// result fields stay put until a new word is taken
				if (in_valid && in_ready) begin
					state_d = S_RDREG;
					idx_d = '0;
					moved_d = '0;
				end
			end
			S_RDREG: begin
				rf_raddr = ins_q.src_reg[RegIdxW-1:0];
				state_d = S_ADDR;
			end
			S_ADDR: begin
				// src register arrives; launch dst read
				sreg_d = rf_rdata;
				rf_raddr = ins_q.dst_reg[RegIdxW-1:0];
				saddr_d = (ins_q.src_kind == KIND_PTR) ? ins_q.src_value
					: (ins_q.src_kind == KIND_DISP) ? rf_rdata + ins_q.src_value : rf_rdata;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				dreg_d = rf_rdata;
				daddr_d = (ins_q.dst_kind == KIND_PTR) ? ins_q.dst_value
					: (ins_q.dst_kind == KIND_DISP) ? rf_rdata + ins_q.dst_value : rf_rdata;
				state_d = S_RESULT;
				status_d = ST_DONE;
				if (stopped_q) begin
					status_d = ST_IGNORED;
				end else if (cmd == CMD_HALT) begin
					status_d = ST_HALT;
				end else if (is_push) begin
					if (SpW'(ssize) > sp_q) status_d = ST_OVERFLOW;
					else begin
						sp_d = sp_q - SpW'(ssize);
						stk_d = sp_q - SpW'(ssize);
						state_d = S_BYTE_RD;
					end
				end else if (is_pop) begin
					if ({1'b0, sp_q} + (SpW+1)'(dsize) > (SpW+1)'(MemBytes))
						status_d = ST_UNDERFLOW;
					else begin
						stk_d = sp_q;
						sp_d = sp_q + SpW'(dsize);
						state_d = S_BYTE_RD;
					end
				end else if (is_move) begin
					if (dsize < ssize) status_d = ST_INVALID;
					else state_d = S_BYTE_RD;
				end
			end
			S_BYTE_RD: begin
				// first byte step also finishes operand validation
				if (idx_q == 4'd0 && ((use_src && !src_ok) || (use_dst && !dst_ok))) begin
					status_d = ST_INVALID;
					state_d = S_RESULT;
				end else begin
					mreq.addr = is_pop ? AddrW'(stk_q + SpW'(idx_q))
						: AddrW'(saddr_q + 64'(idx_q));
					state_d = S_BYTE_WAIT;
				end
			end
			S_BYTE_WAIT: begin
				byte_d = src_from_mem ? mrdata : src_byte_now;
				state_d = S_BYTE_WR;
			end
			S_BYTE_WR: begin
				moved_d = moved_q | (64'(byte_q) << sh);
				if (dst_to_mem) begin
					mreq.we = 1'b1;
					mreq.addr = is_push ? AddrW'(stk_q + SpW'(idx_q))
						: AddrW'(daddr_q + 64'(idx_q));
					mreq.wdata = byte_q;
				end else begin
					dreg_d = (dreg_q & ~(64'hFF << sh)) | (64'(byte_q) << sh);
				end
				// a move from a register to itself sees its own updates
				if (ins_q.src_kind == KIND_REG && !dst_to_mem
					&& ins_q.src_reg == ins_q.dst_reg)
					sreg_d = (dreg_q & ~(64'hFF << sh)) | (64'(byte_q) << sh);
				idx_d = idx_q + 4'd1;
				if (idx_q + 4'd1 == xsize) state_d = dst_to_mem ? S_RESULT : S_REG_WB;
				else state_d = S_BYTE_RD;
			end
			S_REG_WB: begin
				rf_we = 1'b1;
				rf_waddr = ins_q.dst_reg[RegIdxW-1:0];
				rf_wdata = dreg_q;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (status_d == ST_HALT || status_q == ST_INVALID
					|| status_q == ST_OVERFLOW || status_q == ST_UNDERFLOW) stopped_d = 1'b1;
				if (status_q != ST_DONE) moved_d = '0;
				out_valid_d = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			sp_q <= SpW'(MemBytes);
			stopped_q <= 1'b0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q <= sp_d;
			stopped_q <= stopped_d;
			clr_q <= clr_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_ready) ins_q <= in_data;
		sreg_q <= sreg_d;
		dreg_q <= dreg_d;
		saddr_q <= saddr_d;
		daddr_q <= daddr_d;
		idx_q <= idx_d;
		moved_q <= moved_d;
		byte_q <= byte_d;
		status_q <= status_d;
		stk_q <= stk_d;
	end

	assign out_valid = out_valid_q;
	assign out_data.status = status_q;
	assign out_data.stack_pointer_now = 14'(sp_q);
	assign out_data.moved_value = moved_q;

	`VMPP_ASSERT_IMP(a_ready_only_idle, in_ready, state_q == S_IDLE, "ready outside idle")
	`VMPP_ASSERT_IMP(a_sp_range, 1'b1, sp_q <= SpW'(MemBytes), "stack pointer out of range")
	`VMPP_ASSERT_NEXT(a_stop_sticky, stopped_q, stopped_q, "stop flag cleared")
endmodule
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
module tb;
	import vmpp_pkg::*;

	// where an operand lives once it has been resolved
	localparam int LOC_REG = 0;
	localparam int LOC_IMM = 1;
	localparam int LOC_MEM = 2;

	// cycles with no word moving on either channel before the run is called dead;
	// covers the memory clearing pass after reset and the long receiver hold-off
	localparam int IDLE_LIMIT = 40000;
	localparam int RANDOM_WORDS = 830;
	localparam int HOLD_CYCLES = 400;

	// shadow of the machine state: predicts one status word per instruction word
	class vm_scoreboard;
		logic [63:0] regs [RegCount];
		logic [7:0] mem [MemBytes];
		int sp;
		bit stopped;
		out_word_t pending [$];
		int errors;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (mem[i]) mem[i] = '0;
			sp = MemBytes;
			stopped = 0;
			errors = 0;
		endfunction

		function bit resolve(logic [2:0] kind, logic [4:0] rg, logic [63:0] v, int size,
				output int lk, output int idx, output logic [63:0] iv);
			logic [63:0] addr;
			lk = LOC_MEM;
			idx = 0;
			iv = '0;
			case (kind)
				KIND_REG: begin
					lk = LOC_REG;
					idx = rg;
					return 1;
				end
				KIND_IMM: begin
					lk = LOC_IMM;
					iv = v;
					return 1;
				end
				KIND_PTR: addr = v;
				KIND_IND: addr = regs[rg];
				KIND_DISP: addr = regs[rg] + v;
				default: return 0;
			endcase
			if (addr > 64'(MemBytes - size))
				return 0;
			idx = int'(addr);
			return 1;
		endfunction

		// forward byte order, so overlapping memory operands see earlier writes
		function logic [63:0] copy_bytes(int sk, int sidx, logic [63:0] sv, int dk, int didx,
				int size);
			logic [63:0] moved;
			logic [7:0] b;
			moved = '0;
			for (int i = 0; i < size; i++) begin
				if (sk == LOC_REG)
					b = regs[sidx][8*i +: 8];
				else if (sk == LOC_IMM)
					b = sv[8*i +: 8];
				else
					b = mem[sidx + i];
				if (dk == LOC_REG)
					regs[didx][8*i +: 8] = b;
				else if (dk == LOC_MEM)
					mem[didx + i] = b;
				moved[8*i +: 8] = b;
			end
			return moved;
		endfunction

		function void note_instruction(in_word_t w);
			int ss, ds, sk, si, dk, di, top;
			logic [63:0] sv, dv;
			out_word_t r;
			ss = 1 << w.src_size_code;
			ds = 1 << w.dst_size_code;
			r.status = ST_DONE;
			r.moved_value = '0;
			if (stopped) begin
				r.status = ST_IGNORED;
			end else begin
				case (w.cmd)
					CMD_HALT: r.status = ST_HALT;
					CMD_MOVE: begin
						if (ds < ss ||
								!resolve(w.src_kind, w.src_reg, w.src_value, ss, sk, si, sv) ||
								!resolve(w.dst_kind, w.dst_reg, w.dst_value, ss, dk, di, dv) ||
								dk == LOC_IMM)
							r.status = ST_INVALID;
						else
							r.moved_value = copy_bytes(sk, si, sv, dk, di, ss);
					end
					CMD_PUSH: begin
						if (ss > sp) begin
							r.status = ST_OVERFLOW;
						end else begin
							// pointer moves even if the operand turns out bad
							sp -= ss;
							if (!resolve(w.src_kind, w.src_reg, w.src_value, ss, sk, si, sv))
								r.status = ST_INVALID;
							else
								r.moved_value = copy_bytes(sk, si, sv, LOC_MEM, sp, ss);
						end
					end
					CMD_POP: begin
						if (sp + ds > MemBytes) begin
							r.status = ST_UNDERFLOW;
						end else begin
							top = sp;
							sp += ds;
							if (!resolve(w.dst_kind, w.dst_reg, w.dst_value, ds, dk, di, dv) ||
									dk == LOC_IMM)
								r.status = ST_INVALID;
							else
								r.moved_value = copy_bytes(LOC_MEM, top, '0, dk, di, ds);
						end
					end
					default: ;
				endcase
			end
			if (r.status inside {ST_HALT, ST_INVALID, ST_OVERFLOW, ST_UNDERFLOW})
				stopped = 1;
			r.stack_pointer_now = 14'(sp);
			pending.push_back(r);
		endfunction

		function void check_status(out_word_t o);
			out_word_t e;
			if (pending.size() == 0) begin
				$error("status word with nothing expected: %p", o);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (o.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, o.status);
				errors++;
			end
			if (o.stack_pointer_now !== e.stack_pointer_now) begin
				$error("stack_pointer_now: expected %0d, got %0d",
					e.stack_pointer_now, o.stack_pointer_now);
				errors++;
			end
			if (o.moved_value !== e.moved_value) begin
				$error("moved_value: expected %h, got %h", e.moved_value, o.moved_value);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_data;
	logic out_valid;
	logic out_ready;
	out_word_t out_data;

	vm_scoreboard sb = new;
	int burst_left = 0;
	int results = 0;
	int idle_cycles = 0;

	vm_move_push_pop_unit_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial clk = 0;
	always #2 clk = ~clk;

	// every field random, unused ones included, so all bits toggle
	function automatic in_word_t raw_word();
		logic [159:0] bits;
		in_word_t w;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
		w = bits[$bits(in_word_t)-1:0];
		return w;
	endfunction

	// mostly a small window so memory words get reused and overlap
	function automatic logic [63:0] pick_addr(int size);
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 64'($urandom_range(0, 63));
		else if (r < 95)
			return 64'($urandom_range(0, MemBytes - size));
		return 64'(MemBytes - size);
	endfunction

	// a valid operand for the given transfer size: a register, an immediate if allowed, or an in-range memory address
	function automatic void pick_operand(int size, bit imm_ok, output logic [2:0] k,
			inout logic [4:0] rg, inout logic [63:0] v);
		int c, j;
		bit found;
		c = $urandom_range(0, 4);
		if (c == KIND_IMM && !imm_ok)
			c = KIND_REG;
		k = 3'(c);
		case (k)
			KIND_IMM: begin
				// small immediates seed registers usable as pointers
				if ($urandom_range(0, 2) == 0)
					v = 64'($urandom_range(0, 255));
			end
			KIND_PTR: v = pick_addr(size);
			KIND_IND: begin
				found = 0;
				j = $urandom_range(0, RegCount - 1);
				for (int n = 0; n < RegCount && !found; n++) begin
					if (sb.regs[(j + n) % RegCount] <= 64'(MemBytes - size)) begin
						rg = 5'((j + n) % RegCount);
						found = 1;
					end
				end
				if (!found) begin
					k = KIND_PTR;
					v = pick_addr(size);
				end
			end
			KIND_DISP: v = pick_addr(size) - sb.regs[rg];
			default: ;
		endcase
	endfunction

	// a well-formed instruction against the current shadow state
	function automatic in_word_t good_word();
		in_word_t w;
		int r, room, op;
		w = raw_word();
		r = $urandom_range(0, 99);
		room = MemBytes - sb.sp;
		if (r < 8) begin
			w.cmd = ($urandom_range(0, 1) == 0) ? CMD_NOP : 3'($urandom_range(5, 7));
			return w;
		end
		op = (r < 56) ? CMD_MOVE : (r < 78) ? CMD_PUSH : CMD_POP;
		// keep the stack shallow and never pop an empty one
		if (op == CMD_PUSH && room > 512)
			op = CMD_POP;
		if (op == CMD_POP && room == 0)
			op = CMD_PUSH;
		w.cmd = 3'(op);
		case (op)
			CMD_MOVE: begin
				w.src_size_code = 2'($urandom_range(0, 3));
				w.dst_size_code = 2'($urandom_range(w.src_size_code, 3));
				pick_operand(1 << w.src_size_code, 1, w.src_kind, w.src_reg, w.src_value);
				pick_operand(1 << w.src_size_code, 0, w.dst_kind, w.dst_reg, w.dst_value);
			end
			CMD_PUSH:
				pick_operand(1 << w.src_size_code, 1, w.src_kind, w.src_reg, w.src_value);
			default: begin
				while ((1 << w.dst_size_code) > room)
					w.dst_size_code--;
				pick_operand(1 << w.dst_size_code, 0, w.dst_kind, w.dst_reg, w.dst_value);
			end
		endcase
		return w;
	endfunction

	// one instruction that stops the machine; only one fits in a run
	function automatic in_word_t stopping_word();
		in_word_t w;
		w = raw_word();
		w.cmd = CMD_MOVE;
		w.src_kind = KIND_REG;
		w.dst_kind = KIND_REG;
		w.src_size_code = 2'd0;
		w.dst_size_code = 2'd3;
		case ($urandom_range(0, 6))
			0: w.cmd = CMD_HALT;
			1: begin
				// destination narrower than source
				w.src_size_code = 2'd3;
				w.dst_size_code = 2'($urandom_range(0, 2));
			end
			2: w.src_kind = 3'($urandom_range(5, 7));
			3: w.dst_kind = KIND_IMM;
			4: begin
				w.src_kind = KIND_PTR;
				w.src_value = ($urandom_range(0, 1) == 0) ?
					64'(MemBytes + $urandom_range(0, 100)) : {1'b1, w.src_value[62:0]};
			end
			5: begin
				// underflow when the stack is nearly empty, else a halt
				w.cmd = (MemBytes - sb.sp < 8) ? CMD_POP : CMD_HALT;
			end
			default: begin
				// push with a bad source: pointer still moves
				w.cmd = CMD_PUSH;
				w.src_kind = KIND_PTR;
				w.src_value = 64'(MemBytes);
			end
		endcase
		return w;
	endfunction

	function automatic in_word_t mk(logic [2:0] cmd, logic [2:0] sk, logic [1:0] ssc,
			logic [4:0] sr, logic [63:0] sv, logic [2:0] dk, logic [1:0] dsc, logic [4:0] dr,
			logic [63:0] dv);
		in_word_t w;
		w.cmd = cmd;
		w.src_kind = sk;
		w.src_size_code = ssc;
		w.src_reg = sr;
		w.src_value = sv;
		w.dst_kind = dk;
		w.dst_size_code = dsc;
		w.dst_reg = dr;
		w.dst_value = dv;
		return w;
	endfunction

	// offer one word, idling between bursts, and record it once accepted
	task automatic send_word(in_word_t w);
		if (burst_left == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 4))
				@(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		in_valid <= 1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_instruction(w);
		burst_left--;
	endtask

	// receiver: stall pattern changes at random, plus one long hold-off
	initial begin
		int mode;
		int hold_left;
		bit held;
		mode = 0;
		hold_left = 0;
		held = 0;
		out_ready = 0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				mode = $urandom_range(0, 2);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 0;
			end else if (!held && results >= 150) begin
				// block fills and the sender sees in_ready stay low
				held = 1;
				hold_left = HOLD_CYCLES;
				out_ready <= 0;
			end else begin
				case (mode)
					0: out_ready <= 1;
					1: out_ready <= ($urandom_range(0, 1) == 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// result check and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				sb.check_status(out_data);
				results++;
				idle_cycles = 0;
			end else if (in_valid && in_ready) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles > IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		in_valid = 0;
		in_data = '0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// directed: nop and unknown commands
		send_word(mk(CMD_NOP, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(mk(3'd5, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(mk(3'd6, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(mk(3'd7, 7, 3, 31, '1, 7, 3, 31, '1));
		// all-ones immediate, then a byte into it: upper bytes kept
		send_word(mk(CMD_MOVE, KIND_IMM, 3, 0, '1, KIND_REG, 3, 1, 0));
		send_word(mk(CMD_MOVE, KIND_IMM, 0, 0, 64'h55, KIND_REG, 3, 1, 0));
		// register onto itself
		send_word(mk(CMD_MOVE, KIND_REG, 3, 1, 0, KIND_REG, 3, 1, 0));
		// lowest and highest memory words
		send_word(mk(CMD_MOVE, KIND_REG, 3, 1, 0, KIND_PTR, 3, 0, 0));
		send_word(mk(CMD_MOVE, KIND_REG, 3, 1, 0, KIND_PTR, 3, 0, 64'(MemBytes - 8)));
		send_word(mk(CMD_MOVE, KIND_PTR, 3, 0, 64'(MemBytes - 8), KIND_REG, 3, 31, 0));
		// indirect and wrapping displacement through r2 = 16
		send_word(mk(CMD_MOVE, KIND_IMM, 2, 0, 16, KIND_REG, 3, 2, 0));
		send_word(mk(CMD_MOVE, KIND_IMM, 2, 0, 64'h89abcdef, KIND_IND, 2, 2, 0));
		send_word(mk(CMD_MOVE, KIND_DISP, 3, 2, -64'sd16, KIND_REG, 3, 3, 0));
		// overlapping source and destination
		send_word(mk(CMD_MOVE, KIND_PTR, 3, 0, 0, KIND_PTR, 3, 0, 1));
		// stack round trip
		send_word(mk(CMD_PUSH, KIND_IMM, 3, 0, 64'h0123456789abcdef, 0, 0, 0, 0));
		send_word(mk(CMD_PUSH, KIND_REG, 2, 31, 0, 0, 0, 0, 0));
		send_word(mk(CMD_PUSH, KIND_IND, 1, 2, 0, 0, 0, 0, 0));
		send_word(mk(CMD_POP, 0, 0, 0, 0, KIND_PTR, 1, 0, 100));
		send_word(mk(CMD_POP, 0, 0, 0, 0, KIND_REG, 3, 4, 0));
		send_word(mk(CMD_POP, 0, 0, 0, 0, KIND_DISP, 2, 2, 40));

		repeat (RANDOM_WORDS) send_word(good_word());
		send_word(stopping_word());
		// everything after this is ignored
		repeat (15) send_word(raw_word());
		@(posedge clk);
		in_valid <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
